FILE: design/ip_address_text_parser_assert.svh
// Assertion macros shared by the address text parser.
`ifndef IP_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define IP_ADDRESS_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IATP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iatp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IATP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iatp: next-cycle check failed");

`endif

FILE: design/iatp_pkg.sv
// Package: beat types, character codes and limits for the address text parser.
package iatp_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // Limits
  localparam logic [11:0] OCTET_MAX     = 12'd255;
  localparam logic [4:0]  ADDR_BYTES    = 5'd16;
  localparam logic [4:0]  GROUP_PUT_MAX = 5'd14;
  localparam logic [4:0]  QUAD_PUT_MAX  = 5'd12;
  localparam logic [2:0]  QUAD_OCTETS   = 3'd4;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_six;
  } text_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } result_t;

  // Finished string: bytes right-aligned in write order, split into the
  // part before the gap (head) and the part after it (tail).
  typedef struct packed {
    logic         ok;
    logic [127:0] store;
    logic [4:0]   head_n;
    logic [4:0]   tail_n;
  } snap_t;

endpackage

FILE: design/iatp_scan.sv
// Character scanner: per-string parse state and the finished-string register.
module iatp_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_ready,
  input  iatp_pkg::text_t  text,
  output logic             snap_valid,
  input  logic             snap_ready,
  output iatp_pkg::snap_t  snap
);
  import iatp_pkg::*;

  typedef struct packed {
    logic [127:0] store;
    logic [4:0]   wpos;
    logic [4:0]   gpos;
    logic         gap;
    logic [15:0]  hex;
    logic         saw_hex;
    logic [7:0]   dec;
    logic         dec_ok;
    logic         dotted;
    logic [2:0]   octets;
    logic         saw_dec;
    logic         failed;
    logic         at_start;
    logic         colon_pend;
    logic         six;
  } scan_st_t;

  localparam scan_st_t ST_RESET = '{dec_ok: 1'b1, at_start: 1'b1, default: '0};
  localparam scan_st_t ST_CLEAR = '{dec_ok: 1'b1, default: '0};

  scan_st_t st, st_next;
  snap_t    snap_next;
  logic     accept;

  assign text_ready = !snap_valid || snap_ready;
  assign accept     = text_valid && text_ready;

  always_comb begin
    scan_st_t     cur;
    logic         dig, lc, uc, hex_ok;
    logic [3:0]   hval;
    logic [11:0]  dec_nv;
    logic [2:0]   oc_inc;
    logic [127:0] fs;
    logic [4:0]   fw, head, tail;
    logic         good;

    cur = st;
    if (st.at_start) begin
      cur     = ST_CLEAR;
      cur.six = text.is_six;
    end
    st_next = cur;

    dig    = (text.ch >= CH_0) && (text.ch <= CH_9);
    lc     = (text.ch >= CH_LA) && (text.ch <= CH_LF);
    uc     = (text.ch >= CH_UA) && (text.ch <= CH_UF);
    hex_ok = dig || lc || uc;
    hval   = dig ? text.ch[3:0] : text.ch[3:0] + 4'd9;
    dec_nv = ({4'd0, cur.dec} << 3) + ({4'd0, cur.dec} << 1) + {8'd0, text.ch[3:0]};
    oc_inc = cur.octets + 3'd1;

    fs   = cur.store;
    fw   = cur.wpos;
    head = '0;
    tail = ADDR_BYTES;
    good = 1'b1;

    if (st.at_start && text.is_six && text.ch == CH_COLON) begin
      // leading colon: the next character must be a colon too
      st_next.colon_pend = 1'b1;
    end else if (text.ch != CH_NUL) begin
      if (!cur.failed) begin
        if (cur.six && !cur.dotted) begin
          st_next.colon_pend = 1'b0;
          if (cur.colon_pend && cur.wpos == 5'd0 && text.ch != CH_COLON) begin
            st_next.failed = 1'b1;
          end else if (hex_ok) begin
            if (cur.hex[15:12] != 4'd0) begin
              st_next.failed = 1'b1;
            end else begin
              st_next.hex     = {cur.hex[11:0], hval};
              st_next.saw_hex = 1'b1;
              if (dig) begin
                if (dec_nv > OCTET_MAX) st_next.dec_ok = 1'b0;
                else                    st_next.dec    = dec_nv[7:0];
                st_next.saw_dec = 1'b1;
              end else begin
                st_next.dec_ok = 1'b0;
              end
            end
          end else if (text.ch == CH_COLON) begin
            st_next.dec     = '0;
            st_next.dec_ok  = 1'b1;
            st_next.saw_dec = 1'b0;
            if (!cur.saw_hex) begin
              // empty group: this is the gap
              if (cur.gap) begin
                st_next.failed = 1'b1;
              end else begin
                st_next.gap  = 1'b1;
                st_next.gpos = cur.wpos;
              end
            end else if (cur.wpos > GROUP_PUT_MAX) begin
              st_next.failed = 1'b1;
            end else begin
              st_next.store      = {cur.store[111:0], cur.hex};
              st_next.wpos       = cur.wpos + 5'd2;
              st_next.hex        = '0;
              st_next.saw_hex    = 1'b0;
              st_next.colon_pend = 1'b1;
            end
          end else if (text.ch == CH_DOT) begin
            // embedded dotted quad: the group just read was its first octet
            if (cur.wpos > QUAD_PUT_MAX || !cur.dec_ok || !cur.saw_dec) begin
              st_next.failed = 1'b1;
            end else begin
              st_next.store   = {cur.store[119:0], cur.dec};
              st_next.wpos    = cur.wpos + 5'd1;
              st_next.dec     = '0;
              st_next.saw_dec = 1'b0;
              st_next.octets  = 3'd1;
              st_next.dotted  = 1'b1;
              st_next.hex     = '0;
              st_next.saw_hex = 1'b0;
            end
          end else begin
            st_next.failed = 1'b1;
          end
        end else begin
          // dotted quad character
          if (dig) begin
            if (dec_nv > OCTET_MAX) begin
              st_next.failed = 1'b1;
            end else begin
              st_next.dec = dec_nv[7:0];
              if (!cur.saw_dec) begin
                st_next.octets = oc_inc;
                if (oc_inc > QUAD_OCTETS) st_next.failed  = 1'b1;
                else                      st_next.saw_dec = 1'b1;
              end
            end
          end else if (text.ch == CH_DOT && cur.saw_dec) begin
            if (cur.octets == QUAD_OCTETS) begin
              st_next.failed = 1'b1;
            end else begin
              st_next.store   = {cur.store[119:0], cur.dec};
              st_next.wpos    = cur.wpos + 5'd1;
              st_next.dec     = '0;
              st_next.saw_dec = 1'b0;
            end
          end else begin
            st_next.failed = 1'b1;
          end
        end
      end
    end else begin
      // end of string: flush the open token and size the gap
      st_next.at_start = 1'b1;
      if (cur.failed) begin
        good = 1'b0;
      end else if (cur.six) begin
        if (cur.colon_pend) begin
          good = 1'b0;
        end else begin
          if (cur.dotted) begin
            if (cur.octets < QUAD_OCTETS) begin
              good = 1'b0;
            end else begin
              fs = {fs[119:0], cur.dec};
              fw = fw + 5'd1;
            end
          end else if (cur.saw_hex) begin
            if (cur.wpos > GROUP_PUT_MAX) begin
              good = 1'b0;
            end else begin
              fs = {fs[111:0], cur.hex};
              fw = fw + 5'd2;
            end
          end
          if (cur.gap) begin
            if (fw >= ADDR_BYTES || cur.gpos > fw) good = 1'b0;
            head = cur.gpos;
            tail = fw - cur.gpos;
          end else if (fw != ADDR_BYTES) begin
            good = 1'b0;
          end
        end
      end else begin
        if (cur.octets < QUAD_OCTETS) begin
          good = 1'b0;
        end else begin
          fs = {fs[119:0], cur.dec};
        end
      end
    end

    snap_next = '{ok: good, store: fs, head_n: head, tail_n: tail};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_RESET;
      snap_valid <= 1'b0;
    end else begin
      if (accept) st <= st_next;
      if (accept && text.ch == CH_NUL) snap_valid <= 1'b1;
      else if (snap_ready)              snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.ch == CH_NUL) snap <= snap_next;
  end

endmodule

FILE: design/ip_address_text_parser.sv
// Top level of the streaming IPv4/IPv6 address text parser.
//
// Text channel (text_valid/text_ready/text): one beat per ASCII character,
// a NUL character ends the string. The family bit is sampled on the first
// beat of each string (0 dotted quad, 1 IPv6 text).
// Result channel (result_valid/result_ready/result): one beat per string,
// sent for the NUL beat only; ok flags a valid address, and addr_hi/addr_lo
// carry the 128-bit address in network order (IPv4 in the low 32 bits).
// Throughput: one character per cycle while text_ready is high. Each
// character updates the parse state in the cycle it is taken; the NUL beat
// lands in the finished-string register, and the gap expansion shift loads
// the result register from it once the result register is free or draining.
// When the receiver stalls, the result register holds its beat and the
// finished-string register can still take one more string end; text is held
// off only while both are full.
// Reset clears the parse state to the start of a string and empties both
// registers; no clearing pass is needed.
`include "ip_address_text_parser_assert.svh"

module ip_address_text_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_ready,
  input  iatp_pkg::text_t   text,
  output logic              result_valid,
  input  logic              result_ready,
  output iatp_pkg::result_t result
);
  import iatp_pkg::*;

  logic    snap_valid;
  logic    snap_ready;
  snap_t   snap;
  result_t result_next;

  // Scanner: parse state, one character per beat.
  iatp_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // Advance the finished string whenever the result register is free or draining.
  assign snap_ready = !result_valid || result_ready;

  // Expand the gap: head bytes move to the top, tail bytes stay at the bottom,
  // zeros fill between. Without a gap the head is empty and the tail is all.
  always_comb begin
    logic [4:0]   head_sh, tail_sh;
    logic [127:0] head_part, tail_mask, addr;
    head_sh   = ADDR_BYTES - snap.head_n;
    tail_sh   = ADDR_BYTES - snap.tail_n;
    head_part = (snap.store >> {snap.tail_n, 3'b000}) << {head_sh, 3'b000};
    tail_mask = {128{1'b1}} >> {tail_sh, 3'b000};
    addr      = head_part | (snap.store & tail_mask);
    if (!snap.ok) addr = '0;
    result_next = '{ok: snap.ok, addr_hi: addr[127:64], addr_lo: addr[63:0]};
  end

  // Result register: hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) result <= result_next;
  end

  // Checks
  `IATP_ASSERT_NEXT(a_nul_snap, text_valid && text_ready && text.ch == CH_NUL, snap_valid)
  `IATP_ASSERT_NEXT(a_snap_hold, snap_valid && !snap_ready, snap_valid && $stable(snap))
  `IATP_ASSERT_IMPL(a_snap_span, snap_valid && snap.ok, ({1'b0, snap.head_n} + {1'b0, snap.tail_n}) <= 6'd16)
  `IATP_ASSERT_IMPL(a_fail_zero, result_valid && !result.ok, result.addr_hi == 64'd0 && result.addr_lo == 64'd0)

endmodule

FILE: tb/sv/ip_address_text_parser_checker.sv
// Checker for the address text parser: predicts each string's result and compares beats.
`timescale 1ns / 100ps

module ip_address_text_parser_checker
  import iatp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  input  logic        text_ready,
  input  text_t       text,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  output int unsigned fail_count,
  output int unsigned backlog
);

  // Parse state of the string in flight
  logic [7:0]  addr_b [16];
  logic [4:0]  put_at;
  logic [4:0]  gap_at;
  logic [15:0] grp;
  logic [7:0]  oct;
  logic [2:0]  oct_cnt;
  bit          gap_on, grp_any, oct_ok, oct_any, quad_on;
  bit          broken, fresh, colon_wait, v6;

  result_t     addr_due [$];
  int unsigned bad_beats;
  int unsigned beats_seen;

  task automatic clear_line();
    for (int i = 0; i < 16; i++) addr_b[i] = 8'h00;
    put_at     = '0;
    gap_at     = '0;
    gap_on     = 1'b0;
    grp        = '0;
    grp_any    = 1'b0;
    oct        = '0;
    oct_ok     = 1'b1;
    quad_on    = 1'b0;
    oct_cnt    = '0;
    oct_any    = 1'b0;
    broken     = 1'b0;
    colon_wait = 1'b0;
  endtask

  task automatic put_octet(input logic [7:0] v);
    addr_b[put_at[3:0]] = v;
    put_at = put_at + 5'd1;
  endtask

  // Dotted decimal character, IPv4 strings and the tail of an embedded quad
  task automatic quad_step(input logic [7:0] c);
    int nv;
    if (c >= CH_0 && c <= CH_9) begin
      nv = 10 * oct + (c - CH_0);
      if (nv > 255) begin
        broken = 1'b1;
        return;
      end
      oct = nv[7:0];
      if (!oct_any) begin
        oct_cnt = oct_cnt + 3'd1;
        if (oct_cnt > QUAD_OCTETS) begin
          broken = 1'b1;
          return;
        end
        oct_any = 1'b1;
      end
    end else if (c == CH_DOT && oct_any) begin
      if (oct_cnt == QUAD_OCTETS) begin
        broken = 1'b1;
        return;
      end
      put_octet(oct);
      oct     = '0;
      oct_any = 1'b0;
    end else begin
      broken = 1'b1;
    end
  endtask

  // IPv6 hex text character
  task automatic six_step(input logic [7:0] c);
    int h, nv;
    bit lead;
    if (colon_wait) begin
      lead       = (put_at == 0);
      colon_wait = 1'b0;
      if (lead && c != CH_COLON) begin
        broken = 1'b1;
        return;
      end
    end
    if (c >= CH_0 && c <= CH_9)       h = c - CH_0;
    else if (c >= CH_LA && c <= CH_LF) h = c - CH_LA + 10;
    else if (c >= CH_UA && c <= CH_UF) h = c - CH_UA + 10;
    else                               h = -1;
    if (h >= 0) begin
      if (grp[15:12] != 4'h0) begin
        broken = 1'b1;
        return;
      end
      grp     = {grp[11:0], h[3:0]};
      grp_any = 1'b1;
      // Track the same digits as a decimal octet in case a dot follows
      if (c <= CH_9) begin
        nv = 10 * oct + (c - CH_0);
        if (nv > 255) oct_ok = 1'b0;
        else oct = nv[7:0];
        oct_any = 1'b1;
      end else begin
        oct_ok = 1'b0;
      end
      return;
    end
    if (c == CH_COLON) begin
      oct     = '0;
      oct_ok  = 1'b1;
      oct_any = 1'b0;
      if (!grp_any) begin
        if (gap_on) begin
          broken = 1'b1;
          return;
        end
        gap_on = 1'b1;
        gap_at = put_at;
        return;
      end
      if (put_at > GROUP_PUT_MAX) begin
        broken = 1'b1;
        return;
      end
      put_octet(grp[15:8]);
      put_octet(grp[7:0]);
      grp        = '0;
      grp_any    = 1'b0;
      colon_wait = 1'b1;
      return;
    end
    if (c == CH_DOT) begin
      if (put_at > QUAD_PUT_MAX || !oct_ok || !oct_any) begin
        broken = 1'b1;
        return;
      end
      put_octet(oct);
      oct     = '0;
      oct_any = 1'b0;
      oct_cnt = 3'd1;
      quad_on = 1'b1;
      grp     = '0;
      grp_any = 1'b0;
      return;
    end
    broken = 1'b1;
  endtask

  // String end: finish the last token, expand the gap, queue the result
  task automatic close_line();
    logic [127:0] a;
    bit           good;
    int           n, first;
    result_t      r;
    a    = '0;
    good = 1'b0;
    if (broken) begin
      good = 1'b0;
    end else if (!v6) begin
      if (oct_cnt >= QUAD_OCTETS) begin
        put_octet(oct);
        a[31:0] = {addr_b[0], addr_b[1], addr_b[2], addr_b[3]};
        good    = 1'b1;
      end
    end else begin
      good = 1'b1;
      if (colon_wait) begin
        good = 1'b0;
      end else if (quad_on) begin
        if (oct_cnt < QUAD_OCTETS) good = 1'b0;
        else put_octet(oct);
      end else if (grp_any) begin
        if (put_at > GROUP_PUT_MAX) begin
          good = 1'b0;
        end else begin
          put_octet(grp[15:8]);
          put_octet(grp[7:0]);
        end
      end
      if (good) begin
        if (gap_on) begin
          if (put_at >= ADDR_BYTES || gap_at > put_at) begin
            good = 1'b0;
          end else begin
            n     = put_at - gap_at;
            first = 16 - n;
            for (int i = 0; i < 16; i++) begin
              if (i < gap_at) a[127 - 8 * i -: 8] = addr_b[i];
              else if (i >= first) a[127 - 8 * i -: 8] = addr_b[(gap_at + i - first) % 16];
            end
          end
        end else if (put_at != ADDR_BYTES) begin
          good = 1'b0;
        end else begin
          for (int i = 0; i < 16; i++) a[127 - 8 * i -: 8] = addr_b[i];
        end
      end
    end
    r.ok      = good;
    r.addr_hi = good ? a[127:64] : 64'h0;
    r.addr_lo = good ? a[63:0] : 64'h0;
    addr_due.push_back(r);
    fresh = 1'b1;
  endtask

  task automatic take_char(input text_t t);
    if (fresh) begin
      clear_line();
      v6    = t.is_six;
      fresh = 1'b0;
      if (v6 && t.ch == CH_COLON) begin
        colon_wait = 1'b1;
        return;
      end
    end
    if (t.ch != CH_NUL) begin
      if (!broken) begin
        if (v6 && !quad_on) six_step(t.ch);
        else quad_step(t.ch);
      end
    end else begin
      close_line();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      fresh = 1'b1;
      v6    = 1'b0;
      addr_due.delete();
      bad_beats  = 0;
      beats_seen = 0;
    end else begin
      if (text_valid && text_ready) take_char(text);
      if (result_valid && result_ready) begin
        beats_seen++;
        if (addr_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("result beat %0d with no string end pending: ok=%0b hi=%h lo=%h",
                     beats_seen, result.ok, result.addr_hi, result.addr_lo);
        end else begin
          automatic result_t want = addr_due.pop_front();
          if (result.ok !== want.ok || result.addr_hi !== want.addr_hi ||
              result.addr_lo !== want.addr_lo) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("result beat %0d: expected ok=%0b hi=%h lo=%h, got ok=%0b hi=%h lo=%h",
                       beats_seen, want.ok, want.addr_hi, want.addr_lo,
                       result.ok, result.addr_hi, result.addr_lo);
          end
        end
      end
    end
    fail_count <= bad_beats;
    backlog    <= addr_due.size();
  end

endmodule

FILE: tb/sv/tb_ip_address_text_parser.sv
// Testbench top: drives address text into the parser and gives the verdict.
`timescale 1ns / 100ps

module tb_ip_address_text_parser;
  import iatp_pkg::*;

  localparam int ITEMS = 1500;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  text_t       text = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  int unsigned fail_count;
  int unsigned backlog;

  // Characters of the string being built, without its closing NUL
  logic [7:0]  text_q [$];
  int          chars_sent = 0;
  int          burst_left = 0;

  ip_address_text_parser dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text         (text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  ip_address_text_parser_checker chk (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text         (text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .backlog      (backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up well past the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: switch at random between stall patterns so that
  // back-pressure lands on every stage, including long stretches of none.
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       stall_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(16, 96);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   result_ready <= 1'b1;
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          result_ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(0, 12);
          result_ready <= 1'b1;
        end
      end
    endcase
  end

  // Offer one character beat and hold it until taken. Called at a falling
  // edge; returns at the falling edge after the beat was accepted. Bursts
  // of random length are separated by random gaps, sometimes none.
  task automatic send_char(input logic [7:0] c, input logic fam);
    int idle_n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle_n     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (idle_n != 0) begin
        text_valid <= 1'b0;
        repeat (idle_n) @(negedge clk);
      end
    end
    burst_left--;
    text_valid <= 1'b1;
    text       <= text_t'{ch: c, is_six: fam};
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  // Send the built string and its NUL. Only the first beat's family bit
  // counts, so scramble the rest.
  task automatic send_line(input logic fam);
    for (int i = 0; i < text_q.size(); i++)
      send_char(text_q[i], (i == 0) ? fam : 1'($urandom_range(0, 1)));
    send_char(CH_NUL, (text_q.size() == 0) ? fam : 1'($urandom_range(0, 1)));
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Append one decimal octet, biased to the extremes, now and then out of
  // range or with leading zeros.
  task automatic add_octet();
    int v, r;
    r = $urandom_range(0, 15);
    if (r == 0)     v = $urandom_range(256, 999);
    else if (r < 4) v = 0;
    else if (r < 7) v = 255;
    else            v = $urandom_range(0, 255);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(CH_0);
    if (v >= 100) text_q.push_back(8'(CH_0 + v / 100));
    if (v >= 10)  text_q.push_back(8'(CH_0 + (v / 10) % 10));
    text_q.push_back(8'(CH_0 + v % 10));
  endtask

  initial begin
    logic        fam;
    bit          quad;
    int          kind, n, g, slots, width, nib, pos;
    logic [15:0] grp_v;
    string       marks;

    marks = ":.09afAFgx";

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings: empty string, a high code that latches the error,
    // lone leading colon, trailing colon, embedded quad behind a gap,
    // all-ones group with a trailing gap, and octet extremes.
    load_text("");
    send_line(1'b0);
    text_q = '{8'hFF, CH_0};
    send_line(1'b0);
    load_text(":1");
    send_line(1'b1);
    load_text("a:");
    send_line(1'b1);
    load_text("::1.2.3.4");
    send_line(1'b1);
    load_text("FFFF::");
    send_line(1'b1);
    load_text("255.0.9.01");
    send_line(1'b0);

    // Random strings: mostly well formed with random content, some broken
    // on purpose, some pure noise.
    while (chars_sent < ITEMS) begin
      text_q.delete();
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // dotted quad, occasionally with the wrong octet count
        fam = 1'b0;
        n   = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : 4;
        for (int k = 0; k < n; k++) begin
          if (k != 0) text_q.push_back(CH_DOT);
          add_octet();
        end
      end else if (kind < 9) begin
        // IPv6: groups, maybe one gap (now and then with no room left),
        // maybe an embedded quad in place of the last two groups
        fam   = 1'b1;
        quad  = ($urandom_range(0, 3) == 0);
        slots = quad ? 6 : 8;
        if ($urandom_range(0, 1) == 0) begin
          n = $urandom_range(0, slots);
          g = $urandom_range(0, n);
        end else begin
          n = slots;
          g = -1;
        end
        for (int k = 0; k < n; k++) begin
          if (k == g) begin
            text_q.push_back(CH_COLON);
            text_q.push_back(CH_COLON);
          end else if (k != 0) begin
            text_q.push_back(CH_COLON);
          end
          case ($urandom_range(0, 3))
            0:       grp_v = 16'h0000;
            1:       grp_v = 16'hFFFF;
            2:       grp_v = 16'($urandom_range(0, 255));
            default: grp_v = 16'($urandom);
          endcase
          if (grp_v[15:12] != 0)     width = 4;
          else if (grp_v[11:8] != 0) width = 3;
          else if (grp_v[7:4] != 0)  width = 2;
          else                       width = 1;
          if ($urandom_range(0, 3) == 0) width = $urandom_range(width, 4);
          for (int d = width - 1; d >= 0; d--) begin
            nib = (grp_v >> (4 * d)) & 16'hF;
            if (nib < 10)                   text_q.push_back(8'(CH_0 + nib));
            else if ($urandom_range(0, 1)) text_q.push_back(8'(CH_UA + nib - 10));
            else                            text_q.push_back(8'(CH_LA + nib - 10));
          end
        end
        if (g == n) begin
          text_q.push_back(CH_COLON);
          text_q.push_back(CH_COLON);
        end else if (quad) begin
          text_q.push_back(CH_COLON);
        end
        if (quad) begin
          for (int k = 0; k < 4; k++) begin
            if (k != 0) text_q.push_back(CH_DOT);
            add_octet();
          end
        end
      end else begin
        // noise over the whole code range
        fam = 1'($urandom_range(0, 1));
        repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(1, 255)));
      end

      // Break a quarter of the well-formed strings
      if (kind < 9 && $urandom_range(0, 3) == 0) begin
        pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 4))
          0: if (text_q.size() != 0) text_q[pos] = 8'($urandom_range(1, 255));
          1: text_q.insert($urandom_range(0, text_q.size()),
                           marks[$urandom_range(0, marks.len() - 1)]);
          2: if (text_q.size() != 0) text_q.delete(pos);
          3: while (text_q.size() > pos) void'(text_q.pop_back());
          default: text_q.push_back($urandom_range(0, 1) ? CH_COLON : CH_DOT);
        endcase
      end
      send_line(fam);
    end

    // Drain: drop valid, wait for every pending result, then allow the
    // finished-string and result registers to show any stray beat.
    text_valid <= 1'b0;
    while (backlog != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && backlog == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/iatp_pkg.sv
design/iatp_scan.sv
design/ip_address_text_parser.sv
tb/sv/ip_address_text_parser_checker.sv
tb/sv/tb_ip_address_text_parser.sv
